// File: sv/jws_pkg.sv
// ----------------------------------------------------------------------------
// jws_pkg
// Shared codes, register indexes and the command/status types that join the
// Jaro-Winkler controller to its datapath.
// ----------------------------------------------------------------------------
package jws_pkg;

  // Store depth and fraction bits of every score
  localparam int unsigned MAX_LEN   = 64;
  localparam int unsigned FRAC_BITS = 16;

  // Input commands
  localparam logic [1:0] CMD_FIRST   = 2'd0;
  localparam logic [1:0] CMD_SECOND  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_PREFIX_LIMIT = 2'd0;
  localparam logic [1:0] REG_SCALE_FACTOR = 2'd1;
  localparam logic [1:0] REG_THRESHOLD    = 2'd2;

  localparam int unsigned CFG_W = 17;

  localparam logic [2:0]  PREFIX_LIMIT_RST = 3'd4;
  localparam logic [14:0] SCALE_FACTOR_RST = 15'd6554;
  localparam logic [16:0] THRESHOLD_RST    = 17'd45875;

  // Datapath operations, one per cycle
  localparam int unsigned OP_W = 5;
  localparam logic [OP_W-1:0] OP_IDLE    = 5'd0;
  localparam logic [OP_W-1:0] OP_APPEND  = 5'd1;
  localparam logic [OP_W-1:0] OP_INIT    = 5'd2;
  localparam logic [OP_W-1:0] OP_MSET    = 5'd3;
  localparam logic [OP_W-1:0] OP_MCMP    = 5'd4;
  localparam logic [OP_W-1:0] OP_TINIT   = 5'd5;
  localparam logic [OP_W-1:0] OP_TSCAN   = 5'd6;
  localparam logic [OP_W-1:0] OP_TCMP    = 5'd7;
  localparam logic [OP_W-1:0] OP_ZERO    = 5'd8;
  localparam logic [OP_W-1:0] OP_P1      = 5'd9;
  localparam logic [OP_W-1:0] OP_P2      = 5'd10;
  localparam logic [OP_W-1:0] OP_P3      = 5'd11;
  localparam logic [OP_W-1:0] OP_P4      = 5'd12;
  localparam logic [OP_W-1:0] OP_P5      = 5'd13;
  localparam logic [OP_W-1:0] OP_DINIT   = 5'd14;
  localparam logic [OP_W-1:0] OP_DSTEP   = 5'd15;
  localparam logic [OP_W-1:0] OP_JSAT    = 5'd16;
  localparam logic [OP_W-1:0] OP_PINIT   = 5'd17;
  localparam logic [OP_W-1:0] OP_PCMP    = 5'd18;
  localparam logic [OP_W-1:0] OP_NOBOOST = 5'd19;
  localparam logic [OP_W-1:0] OP_B1      = 5'd20;
  localparam logic [OP_W-1:0] OP_B2      = 5'd21;
  localparam logic [OP_W-1:0] OP_B3      = 5'd22;
  localparam logic [OP_W-1:0] OP_EMIT    = 5'd23;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic i_lt_la;   // first-string index still inside the string
    logic j_ge_hi;   // window probe ran past its upper bound
    logic m_hit;     // probe found an unmatched equal character
    logic m_zero;    // no matches at all
    logic t_ready;   // matched pair lined up for the transposition compare
    logic div_last;  // final divider step
    logic boost_en;  // jaro above threshold
    logic p_lt_lim;  // prefix counter below its limit
    logic p_match;   // prefix characters equal
    logic out_full;  // output register cannot take a new result
  } sts_t;

endpackage

// File: sv/jws_ctrl.sv
// ----------------------------------------------------------------------------
// jws_ctrl
// Sequencer: accepts items, then walks matching, transposition scan,
// arithmetic, division, prefix scan and boost, issuing one op per cycle.
// ----------------------------------------------------------------------------
module jws_ctrl
  import jws_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] cmd_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       in_stall_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_INIT  = 5'd1;
  localparam logic [4:0] S_MTOP  = 5'd2;
  localparam logic [4:0] S_MWAIT = 5'd3;
  localparam logic [4:0] S_MCMP  = 5'd4;
  localparam logic [4:0] S_TSCAN = 5'd5;
  localparam logic [4:0] S_TCMP  = 5'd6;
  localparam logic [4:0] S_P1    = 5'd7;
  localparam logic [4:0] S_P2    = 5'd8;
  localparam logic [4:0] S_P3    = 5'd9;
  localparam logic [4:0] S_P4    = 5'd10;
  localparam logic [4:0] S_P5    = 5'd11;
  localparam logic [4:0] S_DINIT = 5'd12;
  localparam logic [4:0] S_DSTEP = 5'd13;
  localparam logic [4:0] S_JSAT  = 5'd14;
  localparam logic [4:0] S_PINIT = 5'd15;
  localparam logic [4:0] S_PTOP  = 5'd16;
  localparam logic [4:0] S_PCMP  = 5'd17;
  localparam logic [4:0] S_B1    = 5'd18;
  localparam logic [4:0] S_B2    = 5'd19;
  localparam logic [4:0] S_B3    = 5'd20;
  localparam logic [4:0] S_DONE  = 5'd21;

  logic [4:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_IDLE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == CMD_FIRST || cmd_i == CMD_SECOND) begin
            cmd_o.op = OP_APPEND;
          end else if (cmd_i == CMD_COMPUTE) begin
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd_o.op = OP_INIT;
        state_d  = S_MTOP;
      end
      S_MTOP: begin
        priority if (sts_i.i_lt_la) begin
          cmd_o.op = OP_MSET;
          state_d  = S_MWAIT;
        end else if (sts_i.m_zero) begin
          cmd_o.op = OP_ZERO;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_TINIT;
          state_d  = S_TSCAN;
        end
      end
      S_MWAIT: state_d = S_MCMP;
      S_MCMP: begin
        cmd_o.op = OP_MCMP;
        state_d  = (sts_i.j_ge_hi || sts_i.m_hit) ? S_MTOP : S_MWAIT;
      end
      S_TSCAN: begin
        cmd_o.op = OP_TSCAN;
        priority if (!sts_i.i_lt_la) begin
          state_d = S_P1;
        end else if (sts_i.t_ready) begin
          state_d = S_TCMP;
        end
      end
      S_TCMP: begin
        cmd_o.op = OP_TCMP;
        state_d  = S_TSCAN;
      end
      S_P1: begin
        cmd_o.op = OP_P1;
        state_d  = S_P2;
      end
      S_P2: begin
        cmd_o.op = OP_P2;
        state_d  = S_P3;
      end
      S_P3: begin
        cmd_o.op = OP_P3;
        state_d  = S_P4;
      end
      S_P4: begin
        cmd_o.op = OP_P4;
        state_d  = S_P5;
      end
      S_P5: begin
        cmd_o.op = OP_P5;
        state_d  = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.op = OP_DINIT;
        state_d  = S_DSTEP;
      end
      S_DSTEP: begin
        cmd_o.op = OP_DSTEP;
        if (sts_i.div_last) begin
          state_d = S_JSAT;
        end
      end
      S_JSAT: begin
        cmd_o.op = OP_JSAT;
        state_d  = S_PINIT;
      end
      S_PINIT: begin
        cmd_o.op = OP_PINIT;
        state_d  = S_PTOP;
      end
      S_PTOP: begin
        priority if (!sts_i.boost_en) begin
          cmd_o.op = OP_NOBOOST;
          state_d  = S_DONE;
        end else if (sts_i.p_lt_lim) begin
          state_d = S_PCMP;
        end else begin
          state_d = S_B1;
        end
      end
      S_PCMP: begin
        cmd_o.op = OP_PCMP;
        state_d  = sts_i.p_match ? S_PTOP : S_B1;
      end
      S_B1: begin
        cmd_o.op = OP_B1;
        state_d  = S_B2;
      end
      S_B2: begin
        cmd_o.op = OP_B2;
        state_d  = S_B3;
      end
      S_B3: begin
        cmd_o.op = OP_B3;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.out_full) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/jws_dp.sv
// ----------------------------------------------------------------------------
// jws_dp
// Datapath: string stores, matched flags, scan counters, product registers,
// restoring divider, boost arithmetic, configuration and result registers.
// ----------------------------------------------------------------------------
module jws_dp
  import jws_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic [1:0]       in_cmd_i,
  input  logic [7:0]       ch_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [16:0]      similarity_o,
  output logic [16:0]      jaro_score_o,
  output logic [6:0]       match_count_o,
  output logic [6:0]       mismatch_count_o,
  output logic [2:0]       prefix_len_o,
  output logic             overflow_o
);

  localparam int unsigned AW  = $clog2(MAX_LEN);
  localparam int unsigned LW  = $clog2(MAX_LEN + 1);
  localparam int unsigned NW  = 3 * LW + 3;
  localparam int unsigned XW  = NW + FRAC_BITS + 1;
  localparam int unsigned CNW = $clog2(XW + 1);
  localparam int unsigned QW  = FRAC_BITS + 2;
  localparam int unsigned PSW = 18;
  localparam int unsigned BPW = PSW + QW;
  localparam int unsigned SW  = BPW + 1;
  localparam int unsigned CW  = (QW > 17) ? QW : 17;
  localparam logic [QW-1:0] OneQ = QW'(1) << FRAC_BITS;
  localparam logic [LW-1:0] MaxLen = LW'(MAX_LEN);

  logic [7:0] mem_a [MAX_LEN];
  logic [7:0] mem_b [MAX_LEN];
  logic [7:0] a_rd_q, b_rd_q;

  logic [LW-1:0]  la_q, lb_q, i_q, j_q, r_q, m_q, t_q, lim_q;
  logic           drop_q;
  logic [MAX_LEN-1:0] fm_q, sm_q;
  logic [2*LW-1:0] p1_q, p2_q;
  logic [3*LW:0]   p3_q, p4_q;
  logic [3*LW-1:0] d_q;
  logic [NW-1:0]   n_q, den_q, rem_q;
  logic [XW-1:0]   x_q;
  logic [QW-1:0]   q_q, jaro_q, sim_q;
  logic [CNW-1:0]  cnt_q;
  logic [2:0]      p_q;
  logic [PSW-1:0]  ps_q;
  logic [BPW-1:0]  bp_q;
  logic [2:0]      plim_q;
  logic [14:0]     sf_q;
  logic [16:0]     thr_q;
  logic            out_valid_q;

  logic            wr_a, wr_b;
  logic [LW:0]     hi, i_ext, lo_full;
  logic [LW-1:0]   lo, half, mx, lim_d;
  logic [NW:0]     div_sh;
  logic [LW:0]     tt;
  logic [SW-1:0]   boost, sim_sum;
  logic            j_lt_lb;

  // Append writes; stores have no reset and no valid bits
  assign wr_a = (cmd_i.op == OP_APPEND) && (in_cmd_i == CMD_FIRST) && (la_q < MaxLen);
  assign wr_b = (cmd_i.op == OP_APPEND) && (in_cmd_i == CMD_SECOND) && (lb_q < MaxLen);

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[la_q[AW-1:0]] <= ch_i;
    end
    if (wr_b) begin
      mem_b[lb_q[AW-1:0]] <= ch_i;
    end
    a_rd_q <= mem_a[i_q[AW-1:0]];
    b_rd_q <= mem_b[j_q[AW-1:0]];
  end

  assign mx      = (la_q > lb_q) ? la_q : lb_q;
  assign half    = mx >> 1;
  assign i_ext   = {1'b0, i_q};
  assign lo_full = i_ext - {1'b0, r_q};
  assign lo      = (i_q > r_q) ? lo_full[LW-1:0] : '0;
  assign hi      = ((i_ext + {1'b0, r_q} + 1'b1) > {1'b0, lb_q}) ? {1'b0, lb_q}
                 : (i_ext + {1'b0, r_q} + 1'b1);
  assign j_lt_lb = j_q < lb_q;
  assign tt      = ({1'b0, m_q} << 1) - {1'b0, t_q};
  assign div_sh  = {rem_q, x_q[XW-1]};
  assign boost   = (SW'(bp_q) + SW'(OneQ >> 1)) >> FRAC_BITS;
  assign sim_sum = SW'(jaro_q) + boost;

  always_comb begin
    lim_d = (la_q < lb_q) ? la_q : lb_q;
    if (LW'(plim_q) < lim_d) begin
      lim_d = LW'(plim_q);
    end
  end

  assign sts_o.i_lt_la  = i_q < la_q;
  assign sts_o.j_ge_hi  = {1'b0, j_q} >= hi;
  assign sts_o.m_hit    = !sm_q[j_q[AW-1:0]] && (a_rd_q == b_rd_q);
  assign sts_o.m_zero   = (m_q == '0);
  assign sts_o.t_ready  = (i_q < la_q) && fm_q[i_q[AW-1:0]] && j_lt_lb
                        && sm_q[j_q[AW-1:0]];
  assign sts_o.div_last = (cnt_q == CNW'(1));
  assign sts_o.boost_en = CW'(jaro_q) > CW'(thr_q);
  assign sts_o.p_lt_lim = i_q < lim_q;
  assign sts_o.p_match  = (a_rd_q == b_rd_q);
  assign sts_o.out_full = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la_q        <= '0;
      lb_q        <= '0;
      drop_q      <= 1'b0;
      fm_q        <= '0;
      sm_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      cnt_q       <= '0;
      plim_q      <= PREFIX_LIMIT_RST;
      sf_q        <= SCALE_FACTOR_RST;
      thr_q       <= THRESHOLD_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PREFIX_LIMIT: plim_q <= cfg_wdata_i[2:0];
          REG_SCALE_FACTOR: sf_q   <= cfg_wdata_i[14:0];
          REG_THRESHOLD:    thr_q  <= cfg_wdata_i[16:0];
          default: ;
        endcase
      end
      // Load a new result, or drop the old one once it is taken
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_APPEND: begin
          if (in_cmd_i == CMD_FIRST) begin
            if (wr_a) la_q <= la_q + 1'b1;
            else      drop_q <= 1'b1;
          end else begin
            if (wr_b) lb_q <= lb_q + 1'b1;
            else      drop_q <= 1'b1;
          end
        end
        OP_INIT: begin
          fm_q <= '0;
          sm_q <= '0;
          m_q  <= '0;
          t_q  <= '0;
          i_q  <= '0;
          r_q  <= (half >= LW'(1)) ? half - 1'b1 : '0;
        end
        OP_MSET: j_q <= lo;
        OP_MCMP: begin
          priority if (sts_o.j_ge_hi) begin
            i_q <= i_q + 1'b1;
          end else if (sts_o.m_hit) begin
            fm_q[i_q[AW-1:0]] <= 1'b1;
            sm_q[j_q[AW-1:0]] <= 1'b1;
            m_q <= m_q + 1'b1;
            i_q <= i_q + 1'b1;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        OP_TINIT: begin
          i_q <= '0;
          j_q <= '0;
        end
        OP_TSCAN: begin
          if (sts_o.i_lt_la) begin
            priority if (!fm_q[i_q[AW-1:0]]) begin
              i_q <= i_q + 1'b1;
            end else if (j_lt_lb && !sm_q[j_q[AW-1:0]]) begin
              j_q <= j_q + 1'b1;
            end else if (!j_lt_lb) begin
              i_q <= i_q + 1'b1;
            end else begin
              i_q <= i_q;
            end
          end
        end
        OP_TCMP: begin
          if (a_rd_q != b_rd_q) begin
            t_q <= t_q + 1'b1;
          end
          i_q <= i_q + 1'b1;
          j_q <= j_q + 1'b1;
        end
        OP_ZERO: begin
          jaro_q <= '0;
          sim_q  <= '0;
          p_q    <= '0;
        end
        OP_P1: p1_q <= la_q * lb_q;
        OP_P2: p2_q <= m_q * m_q;
        OP_P3: p3_q <= p2_q * ({1'b0, la_q} + {1'b0, lb_q});
        OP_P4: p4_q <= tt * p1_q;
        OP_P5: begin
          d_q <= p1_q * m_q;
          n_q <= NW'({p3_q, 1'b0}) + NW'(p4_q);
        end
        OP_DINIT: begin
          // dividend carries half the divisor for round-half-up
          x_q   <= (XW'(n_q) << FRAC_BITS) + (XW'(d_q) << 1) + XW'(d_q);
          den_q <= (NW'(d_q) << 2) + (NW'(d_q) << 1);
          rem_q <= '0;
          q_q   <= '0;
          cnt_q <= CNW'(XW);
        end
        OP_DSTEP: begin
          if (div_sh >= {1'b0, den_q}) begin
            rem_q <= NW'(div_sh - {1'b0, den_q});
            q_q   <= {q_q[QW-2:0], 1'b1};
          end else begin
            rem_q <= div_sh[NW-1:0];
            q_q   <= {q_q[QW-2:0], 1'b0};
          end
          x_q   <= x_q << 1;
          cnt_q <= cnt_q - 1'b1;
        end
        OP_JSAT: jaro_q <= (q_q > OneQ) ? OneQ : q_q;
        OP_PINIT: begin
          lim_q <= lim_d;
          i_q   <= '0;
          j_q   <= '0;
        end
        OP_PCMP: begin
          if (sts_o.p_match) begin
            i_q <= i_q + 1'b1;
            j_q <= j_q + 1'b1;
          end
        end
        OP_NOBOOST: begin
          sim_q <= jaro_q;
          p_q   <= '0;
        end
        OP_B1: begin
          p_q  <= i_q[2:0];
          ps_q <= i_q[2:0] * sf_q;
        end
        OP_B2: bp_q <= ps_q * (OneQ - jaro_q);
        OP_B3: sim_q <= (sim_sum > SW'(OneQ)) ? OneQ : sim_sum[QW-1:0];
        OP_EMIT: begin
          similarity_o     <= 17'(sim_q);
          jaro_score_o     <= 17'(jaro_q);
          match_count_o    <= 7'(m_q);
          mismatch_count_o <= 7'(t_q);
          prefix_len_o     <= p_q;
          overflow_o       <= drop_q;
          la_q             <= '0;
          lb_q             <= '0;
          drop_q           <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: sv/jaro_winkler_similarity_top.sv
// ----------------------------------------------------------------------------
// jaro_winkler_similarity_top
// Jaro-Winkler similarity engine: loads two byte strings, then on a compute
// item emits the Q1.FRAC_BITS Jaro and Jaro-Winkler scores and match counts.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o| cmd_i, ch_i
//  out     | output    | out_valid_o/out_stall_i| similarity_o .. overflow_o
//  cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
//  An append item does not stall the input. A compute item holds the input
//  stalled until its result is emitted; the window probe loop and the one-bit-
//  per-cycle restoring divider (41 steps at the defaults) set how long it lasts.
//  Reset clears both lengths, flags and the result valid bit, and loads the
//  configuration defaults; the string stores need no clearing pass. Appends
//  are taken while a result waits on a stalled output; a compute finishing
//  then holds until it drains.
// ----------------------------------------------------------------------------
module jaro_winkler_similarity_top
  import jws_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       cmd_i,
  input  logic [7:0]       ch_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [16:0]      similarity_o,
  output logic [16:0]      jaro_score_o,
  output logic [6:0]       match_count_o,
  output logic [6:0]       mismatch_count_o,
  output logic [2:0]       prefix_len_o,
  output logic             overflow_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: one op per cycle into the datapath
  jws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // Stores, counters, arithmetic and the output register
  jws_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_cmd_i         (cmd_i),
    .ch_i             (ch_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .similarity_o     (similarity_o),
    .jaro_score_o     (jaro_score_o),
    .match_count_o    (match_count_o),
    .mismatch_count_o (mismatch_count_o),
    .prefix_len_o     (prefix_len_o),
    .overflow_o       (overflow_o)
  );

endmodule

// File: sv/jws_chk.sv
// ----------------------------------------------------------------------------
// jws_chk
// Port-level checks of the similarity engine, bound to the top level.
// ----------------------------------------------------------------------------
module jws_chk
  import jws_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  cmd_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [16:0] similarity_o,
  input logic [16:0] jaro_score_o,
  input logic [6:0]  match_count_o,
  input logic [2:0]  prefix_len_o
);

  localparam bit SmallLen = (MAX_LEN < 128);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i == CMD_COMPUTE |=> in_stall_o)
    else $error("compute item did not hold the input");

  a_no_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && prefix_len_o == 3'd0 |-> similarity_o == jaro_score_o)
    else $error("boost without prefix");

  a_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && SmallLen && match_count_o == 7'd0 |-> similarity_o == 17'd0)
    else $error("nonzero score without matches");

endmodule

bind jaro_winkler_similarity_top jws_chk u_jws_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .cmd_i        (cmd_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .similarity_o (similarity_o),
  .jaro_score_o (jaro_score_o),
  .match_count_o(match_count_o),
  .prefix_len_o (prefix_len_o)
);
